@@ rtl/sdi12_rx_framer_echo_filter_macros.svh @@
// Assertion macros used by the receive framer controller RTL.
`ifndef SDI12_RX_FRAMER_ECHO_FILTER_MACROS_SVH
`define SDI12_RX_FRAMER_ECHO_FILTER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define SDI12RXF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define SDI12RXF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sdi12rxf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdi12rxf_pkg
// Shared constants, types and helpers of the SDI-12 receive framer.
// ----------------------------------------------------------------------------
package sdi12rxf_pkg;

  localparam int DEF_BUFFER_BYTES = 64;

  localparam logic [7:0] LF_BYTE   = 8'h0A;
  localparam logic [7:0] BANG_BYTE = 8'h21;
  localparam logic [6:0] CHAR_MASK = 7'h7F;
  localparam logic [3:0] CMD_MAX   = 4'd8;

  localparam int CMD_TEXT_W = 64;
  localparam int CMD_LEN_W  = 4;

  // Configuration register indexes.
  localparam logic CFG_IDX_TEXT   = 1'b0;
  localparam logic CFG_IDX_LENGTH = 1'b1;

  typedef struct packed {
    logic [CMD_TEXT_W-1:0] text;
    logic [CMD_LEN_W-1:0]  length;
  } sdi12rxf_cfg_t;

  // Command character i, first character in the lowest byte.
  function automatic logic [7:0] cmd_byte(logic [CMD_TEXT_W-1:0] text, int unsigned idx);
    logic [5:0] sel;
    sel = {idx[2:0], 3'b000};
    return text[sel +: 8];
  endfunction

endpackage

@@ rtl/sdi12_rx_framer_echo_filter.sv @@
// ----------------------------------------------------------------------------
// sdi12_rx_framer_echo_filter
// SDI-12 receive framer: stores bus bytes, replays completed frames with
// parity stripped and drops the echo of the last command.
// ----------------------------------------------------------------------------
// Replay: the terminator beat that closes a frame moves the controller to
//   its emit state, whose first read of the frame store loads the first
//   character into the read register; an armed echo check runs before that.
// Throughput: one byte beat per cycle while the controller is idle; a
//   completed frame holds in_tready low while its characters are replayed
//   (plus any output stall) and while an armed echo check reads it back, both
//   through the single read port of the frame store.
// Reset: rst_n synchronous, active low; clears position, echo arm, output
//   valid and configuration. The frame store itself is not cleared.
module sdi12_rx_framer_echo_filter #(
  parameter int BUFFER_BYTES = sdi12rxf_pkg::DEF_BUFFER_BYTES
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [sdi12rxf_pkg::CMD_TEXT_W-1:0] cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] rx_byte
  input  logic                                in_tuser,   // [0] action
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [6:0] answer_char, [7] zero
  output logic                                out_tlast
);
  import sdi12rxf_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);

  sdi12rxf_cfg_t cfg_r;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [7:0]    mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text   <= '0;
      cfg_r.length <= CMD_LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_TEXT:   cfg_r.text   <= cfg_wdata;
        CFG_IDX_LENGTH: cfg_r.length <= cfg_wdata[CMD_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  sdi12rxf_ctrl #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tlast  (out_tlast),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  sdi12rxf_store #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The store's read register is the result register; strip parity here.
  assign out_tdata = {1'b0, mem_rdata[6:0] & CHAR_MASK};

endmodule

@@ rtl/sdi12rxf_store.sv @@
// ----------------------------------------------------------------------------
// sdi12rxf_store
// Frame store: one write port, one read port with a registered read.
// ----------------------------------------------------------------------------
module sdi12rxf_store #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [$clog2(BUFFER_BYTES)-1:0] waddr,
  input  logic [7:0]                      wdata,
  input  logic                            re,
  input  logic [$clog2(BUFFER_BYTES)-1:0] raddr,
  output logic [7:0]                      rdata
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // The read register holds its value while no read is issued; it doubles
  // as the result register of the output channel.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/sdi12rxf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sdi12rxf_ctrl
// Framing, echo check and replay sequencer around the frame store.
// ----------------------------------------------------------------------------
`include "sdi12_rx_framer_echo_filter_macros.svh"

module sdi12rxf_ctrl #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sdi12rxf_pkg::sdi12rxf_cfg_t     cfg,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic                            out_tlast,
  output logic                            mem_we,
  output logic [$clog2(BUFFER_BYTES)-1:0] mem_waddr,
  output logic [7:0]                      mem_wdata,
  output logic                            mem_re,
  output logic [$clog2(BUFFER_BYTES)-1:0] mem_raddr,
  input  logic [7:0]                      mem_rdata
);
  import sdi12rxf_pkg::*;

  localparam int AW = $clog2(BUFFER_BYTES);
  localparam int LW = (AW > CMD_LEN_W) ? AW : CMD_LEN_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_EMIT  = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] wp_r, wp_nxt;
  logic [AW-1:0] cut_len_r, cut_len_nxt;
  logic          zero_seen_r, zero_seen_nxt;
  logic          armed_r, armed_nxt;
  logic [AW-1:0] frm_len_r, frm_len_nxt;
  logic [AW-1:0] rd_idx_r, rd_idx_nxt;
  logic [AW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          chk_pend_r, chk_pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept;
  logic          stored;
  logic          is_term;
  logic          char_zero;
  logic [AW-1:0] wp_inc;
  logic [AW-1:0] cut_after;
  logic [AW-1:0] len_m1;
  logic [3:0]    clen;
  logic          len_is_clen;
  logic          slot_free;
  logic          mismatch;
  logic          chk_issue;

  assign in_tready  = (state_r == ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;

  assign stored    = (wp_r < AW'(BUFFER_BYTES - 1));
  assign is_term   = (in_tdata == LF_BYTE) || (in_tdata == BANG_BYTE);
  assign char_zero = ((in_tdata[6:0] & CHAR_MASK) == 7'd0);
  assign wp_inc    = wp_r + AW'(1);
  assign len_m1    = frm_len_r - AW'(1);
  assign clen      = (cfg.length > CMD_MAX) ? CMD_MAX : cfg.length;
  assign slot_free = !out_valid_r || out_tready;

  // Cut length of the frame once the current byte is stored.
  always_comb begin
    if (wp_r == '0) begin
      cut_after = char_zero ? '0 : AW'(1);
    end else if (zero_seen_r || char_zero) begin
      cut_after = cut_len_r;
    end else begin
      cut_after = wp_inc;
    end
  end

  assign len_is_clen = (LW'(cut_after) == LW'(clen));
  assign mismatch    = chk_pend_r &&
                       ({1'b0, mem_rdata[6:0] & CHAR_MASK} !=
                        cmd_byte(cfg.text, int'(cmp_idx_r)));
  assign chk_issue   = (state_r == ST_CHECK) && !out_valid_r &&
                       (rd_idx_r < frm_len_r) && !mismatch;

  assign mem_we    = accept && !in_tuser && stored;
  assign mem_waddr = wp_r;
  assign mem_wdata = in_tdata;

  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    cut_len_nxt   = cut_len_r;
    zero_seen_nxt = zero_seen_r;
    armed_nxt     = armed_r;
    frm_len_nxt   = frm_len_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    chk_pend_nxt  = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_last_nxt  = out_last_r;
    mem_re        = 1'b0;
    mem_raddr     = rd_idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_tuser) begin
            armed_nxt = 1'b1;
          end else if (!stored) begin
            wp_nxt = '0;
          end else begin
            wp_nxt        = wp_inc;
            cut_len_nxt   = cut_after;
            zero_seen_nxt = (wp_r == '0) ? char_zero : (zero_seen_r || char_zero);
            // A terminator closes the frame once at least two bytes are held.
            if (is_term && (wp_r != '0)) begin
              wp_nxt      = '0;
              frm_len_nxt = cut_after;
              armed_nxt   = 1'b0;
              rd_idx_nxt  = '0;
              cmp_idx_nxt = '0;
              if (cut_after == '0) begin
                state_nxt = ST_IDLE;
              end else if (armed_r && len_is_clen) begin
                state_nxt = ST_CHECK;
              end else begin
                state_nxt = ST_EMIT;
              end
            end
          end
        end
      end

      ST_CHECK: begin
        if (chk_issue) begin
          mem_re       = 1'b1;
          mem_raddr    = rd_idx_r;
          rd_idx_nxt   = rd_idx_r + AW'(1);
          chk_pend_nxt = 1'b1;
        end
        if (mismatch) begin
          state_nxt  = ST_EMIT;
          rd_idx_nxt = '0;
        end else if (chk_pend_r) begin
          cmp_idx_nxt = cmp_idx_r + AW'(1);
          // Every character matched: the frame is the command echo.
          if (cmp_idx_r == len_m1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          mem_re        = 1'b1;
          mem_raddr     = rd_idx_r;
          rd_idx_nxt    = rd_idx_r + AW'(1);
          out_valid_nxt = 1'b1;
          out_last_nxt  = (rd_idx_r == len_m1);
          if (rd_idx_r == len_m1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      cut_len_r   <= '0;
      zero_seen_r <= 1'b0;
      armed_r     <= 1'b0;
      chk_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      cut_len_r   <= cut_len_nxt;
      zero_seen_r <= zero_seen_nxt;
      armed_r     <= armed_nxt;
      chk_pend_r  <= chk_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    frm_len_r  <= frm_len_nxt;
    rd_idx_r   <= rd_idx_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    out_last_r <= out_last_nxt;
  end

  `SDI12RXF_ASSERT_NOW(a_wp_in_range, 1'b1, wp_r <= AW'(BUFFER_BYTES - 1), "write position out of range")
  `SDI12RXF_ASSERT_NOW(a_cut_le_wp, wp_r != '0, cut_len_r <= wp_r, "cut length beyond stored bytes")
  `SDI12RXF_ASSERT_NOW(a_check_no_clobber, chk_issue, !out_valid_r, "echo check read over a pending result")
  `SDI12RXF_ASSERT_NOW(a_no_write_busy, state_r != ST_IDLE, !mem_we, "frame store written while replaying")
  `SDI12RXF_ASSERT_NOW(a_emit_in_frame, state_r == ST_EMIT, rd_idx_r < frm_len_r, "replay index past frame length")

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SDI-12 receive framer. A queue-fed driver sends
// byte and command beats in bursts, and a scoreboard predicts every replayed
// character, including echo drops, cut frames and store overflow. The monitor
// stalls the answer stream on changing patterns and once for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
  import sdi12rxf_pkg::*;

  localparam int DEPTH = DEF_BUFFER_BYTES;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } bus_item_t;

  typedef struct packed {
    logic [6:0] ch;
    logic       last;
  } answer_t;

  typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_MOSTLY} ready_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_IDX_TEXT;
  logic [63:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic        in_tuser = 1'b0; // [0] action
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [6:0] answer_char, [7] zero
  logic        out_tlast;

  bus_item_t pending_beats[$];
  answer_t   answer_q[$];
  int        errors = 0;

  // Scoreboard copy of the framer state and its registers.
  logic [7:0]  rx_buf[DEPTH];
  int          rx_pos = 0;
  bit          echo_pending = 1'b0;
  logic [63:0] cmd_text_cfg = '0;
  logic [3:0]  cmd_len_cfg = 4'd1;

  int gap_left = 0;
  int burst_left = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int mode_left = 0;
  int ready_tick = 0;
  ready_mode_t ready_mode = RDY_ALWAYS;

  sdi12_rx_framer_echo_filter #(.BUFFER_BYTES(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    errors++;
    $display("%0t ns: %s", $time, msg);
  endtask

  function automatic bit is_command_echo(int len);
    logic [3:0] eff;
    eff = (cmd_len_cfg > CMD_MAX) ? CMD_MAX : cmd_len_cfg;
    if (len != eff) return 1'b0;
    for (int i = 0; i < len; i++) begin
      if ({1'b0, rx_buf[i][6:0]} != cmd_text_cfg[8*i +: 8]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic predict_answers(bus_item_t b);
    int  len;
    bit  was_armed;
    if (b.action) begin
      echo_pending = 1'b1;
      return;
    end
    if (rx_pos < DEPTH - 1) begin
      rx_buf[rx_pos] = b.rx_byte;
      rx_pos++;
    end else begin
      rx_pos = 0;
    end
    // The terminator is matched on the raw byte, parity bit included.
    if (!((b.rx_byte == LF_BYTE || b.rx_byte == BANG_BYTE) && rx_pos > 1)) return;
    len = 0;
    while (len < rx_pos && rx_buf[len][6:0] != 7'd0) len++;
    rx_pos = 0;
    was_armed = echo_pending;
    echo_pending = 1'b0;
    if (was_armed && is_command_echo(len)) return;
    for (int i = 0; i < len; i++) begin
      answer_q.push_back(answer_t'{rx_buf[i][6:0], (i == len - 1)});
    end
  endtask

  // Driver: one beat per handshake, sent in bursts with random gaps.
  always @(posedge clk) begin
    bus_item_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_answers(bus_item_t'{in_tuser, in_tdata});
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0 || pending_beats.size() == 0) begin
          in_tvalid <= 1'b0;
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          nxt = pending_beats.pop_front();
          in_tvalid <= 1'b1;
          in_tdata <= nxt.rx_byte;
          in_tuser <= nxt.action;
          if (burst_left <= 1) begin
            if ($urandom_range(0, 7) == 0) begin
              burst_left <= 200;
              gap_left <= 0;
            end else begin
              burst_left <= $urandom_range(1, 40);
              gap_left <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20)
                                                      : $urandom_range(0, 3);
            end
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // Monitor: checks each answer beat and drives the receiver stall pattern.
  always @(posedge clk) begin
    answer_t exp_ans;
    logic    rdy;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (answer_q.size() == 0) begin
          report_mismatch($sformatf("unexpected answer beat data=%h last=%b",
                                    out_tdata, out_tlast));
        end else begin
          exp_ans = answer_q.pop_front();
          if (out_tdata !== {1'b0, exp_ans.ch})
            report_mismatch($sformatf("answer_char got %h, expected %h",
                                      out_tdata, exp_ans.ch));
          if (out_tlast !== exp_ans.last)
            report_mismatch($sformatf("answer_last got %b, expected %b",
                                      out_tlast, exp_ans.last));
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (hold_seen != hold_asks) begin
        hold_seen = hold_asks;
        hold_left = 400;
        rdy = 1'b0;
      end else begin
        if (mode_left == 0) begin
          ready_mode = ready_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        ready_tick++;
        case (ready_mode)
          RDY_ALWAYS: rdy = 1'b1;
          RDY_COIN:   rdy = $urandom_range(0, 1);
          RDY_SPARSE: rdy = (ready_tick % 4 == 0);
          default:    rdy = ($urandom_range(0, 99) < 85);
        endcase
      end
      out_tready <= rdy;
    end
  end

  task automatic cfg_write(logic idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IDX_TEXT) cmd_text_cfg = val;
    else cmd_len_cfg = val[3:0];
    @(negedge clk);
  endtask

  task automatic push_byte(logic [7:0] b);
    pending_beats.push_back(bus_item_t'{1'b0, b});
  endtask

  task automatic push_arm();
    pending_beats.push_back(bus_item_t'{1'b1, 8'($urandom_range(0, 255))});
  endtask

  // Waits until the driver is empty and every expected character has come.
  task automatic wait_idle();
    int waited;
    waited = 0;
    @(negedge clk);
    while ((pending_beats.size() != 0 || in_tvalid || answer_q.size() != 0) &&
           waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    if (answer_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected characters never arrived",
                                answer_q.size()));
      answer_q.delete();
    end
    repeat (80) @(negedge clk);
  endtask

  // Printable command characters, optionally closed by a '!' terminator.
  function automatic logic [63:0] make_command(int n, bit bang_end);
    logic [63:0] t;
    for (int i = 0; i < 8; i++) begin
      t[8*i +: 8] = $urandom_range(8'h30, 8'h7E);
      if (bang_end && i == n - 1) t[8*i +: 8] = BANG_BYTE;
    end
    return t;
  endfunction

  // One random sequence: mostly whole frames, sometimes a command echo,
  // now and then a stray beat or a frame with a broken terminator.
  task automatic add_frame();
    int          r;
    int          n;
    int          eff;
    logic [7:0]  b;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      pending_beats.push_back(bus_item_t'(9'($urandom_range(0, 511))));
      return;
    end
    if ($urandom_range(0, 2) == 0) push_arm();
    if (r < 30) begin
      eff = (cmd_len_cfg > CMD_MAX) ? CMD_MAX : cmd_len_cfg;
      b = 8'h00;
      for (int i = 0; i < eff; i++) begin
        b = cmd_text_cfg[8*i +: 8];
        // Parity on the body only; a flipped terminator would not end the frame.
        if (i < eff - 1) b[7] = $urandom_range(0, 1);
        push_byte(b);
      end
      if (b != LF_BYTE && b != BANG_BYTE) push_byte($urandom_range(0, 1) ? LF_BYTE : BANG_BYTE);
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) n = 0;
      else if (r < 10) n = $urandom_range(58, 70);
      else n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 255);
        else b = {1'($urandom_range(0, 1)), 7'($urandom_range(8'h20, 8'h7E))};
        push_byte(b);
      end
      r = $urandom_range(0, 99);
      if (r < 45) push_byte(LF_BYTE);
      else if (r < 90) push_byte(BANG_BYTE);
      else if (r < 95) push_byte({1'b1, LF_BYTE[6:0]});
    end
  endtask

  task automatic run_frames(int n_beats);
    int start;
    start = pending_beats.size();
    while (pending_beats.size() - start < n_beats) add_frame();
  endtask

  initial begin
    logic [63:0] t;
    int          n;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Command "0M!" with the first character in the lowest byte.
    cfg_write(CFG_IDX_TEXT, 64'h0000_0000_0021_4D30);
    cfg_write(CFG_IDX_LENGTH, 64'd3);

    // Zero first byte: empty frame.
    push_byte(8'h00); push_byte(BANG_BYTE);
    // Echo with a parity bit on its first character is still dropped.
    push_arm(); push_byte(8'hB0); push_byte(8'h4D); push_byte(BANG_BYTE);
    // Armed, but the answer differs from the command.
    push_arm(); push_byte(8'h30); push_byte(8'h2B); push_byte(8'h0D); push_byte(LF_BYTE);
    // Command text without a command event is replayed.
    push_byte(8'h30); push_byte(8'h4D); push_byte(BANG_BYTE);
    // An empty frame uses up the echo check.
    push_arm(); push_byte(8'h80); push_byte(LF_BYTE);
    push_byte(8'h30); push_byte(8'h4D); push_byte(BANG_BYTE);
    // Lone '!' does not end a frame; terminators with parity set do not either.
    push_byte(BANG_BYTE); push_byte(8'h8A); push_byte(8'hFF); push_byte(8'hA1);
    push_byte(BANG_BYTE);
    // Frame cut before a byte whose low seven bits are zero.
    push_byte(8'h61); push_byte(8'h80); push_byte(8'h63); push_byte(LF_BYTE);
    wait_idle();

    run_frames(50);
    wait_idle();

    // Full eight-character command; the answer side holds off for a while.
    t = make_command(8, 1'b1);
    cfg_write(CFG_IDX_TEXT, t);
    cfg_write(CFG_IDX_LENGTH, 64'd8);
    hold_asks++;
    run_frames(60);
    wait_idle();

    // Lengths above eight act as eight.
    cfg_write(CFG_IDX_LENGTH, 64'd15);
    run_frames(25);
    wait_idle();
    run_frames(25);
    wait_idle();

    cfg_write(CFG_IDX_TEXT, make_command(4, 1'b1));
    cfg_write(CFG_IDX_LENGTH, 64'd0);
    run_frames(45);
    wait_idle();

    cfg_write(CFG_IDX_TEXT, '1);
    cfg_write(CFG_IDX_LENGTH, 64'd1);
    run_frames(40);
    wait_idle();

    cfg_write(CFG_IDX_TEXT, '0);
    cfg_write(CFG_IDX_LENGTH, 64'd8);
    run_frames(40);
    wait_idle();

    // A command byte with bit 7 set can never be echoed.
    n = $urandom_range(2, 7);
    t = make_command(n, 1'b1);
    t[8 * $urandom_range(0, n - 2) + 7] = 1'b1;
    cfg_write(CFG_IDX_TEXT, t);
    cfg_write(CFG_IDX_LENGTH, n);
    run_frames(45);
    wait_idle();

    n = $urandom_range(1, 8);
    t = make_command(n, 1'b0);
    t[8*(n-1) +: 8] = LF_BYTE;
    cfg_write(CFG_IDX_TEXT, t);
    cfg_write(CFG_IDX_LENGTH, n);
    run_frames(50);
    wait_idle();

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
